### src/mtrl_pkg.sv
// shared types and constants for the memory type range lookup block
// no dependencies; imported by every module of the block
`default_nettype none

package mtrl_pkg;

   // geometry
   localparam int MTRL_NUM_VARIABLE = 16;
   localparam int MTRL_NUM_FIXED    = 11;
   localparam int ADDR_W            = 52;
   localparam int PAGE_W            = 52;
   localparam int PAGE_SHIFT        = 12;
   localparam int VALUE_W           = 64;
   localparam int FIXED_IDX_W       = 4;

   // request actions
   localparam logic [1:0] ACT_LOOKUP   = 2'd0;
   localparam logic [1:0] ACT_WR_FIXED = 2'd1;
   localparam logic [1:0] ACT_WR_BASE  = 2'd2;
   localparam logic [1:0] ACT_WR_MASK  = 2'd3;

   // memory type codes
   localparam logic [2:0] TYPE_UC = 3'd0;
   localparam logic [2:0] TYPE_WC = 3'd1;
   localparam logic [2:0] TYPE_WT = 3'd4;
   localparam logic [2:0] TYPE_WP = 3'd5;
   localparam logic [2:0] TYPE_WB = 3'd6;

   // one bit per type code in the match set
   localparam logic [6:0] SET_WC    = 7'b0000010;
   localparam logic [6:0] SET_WT    = 7'b0010000;
   localparam logic [6:0] SET_WP    = 7'b0100000;
   localparam logic [6:0] SET_WB    = 7'b1000000;
   localparam logic [6:0] SET_WT_WB = 7'b1010000;

   // control register indexes
   localparam logic [2:0] CSR_MTRR_ENABLE    = 3'd0;
   localparam logic [2:0] CSR_FIXED_ENABLE   = 3'd1;
   localparam logic [2:0] CSR_FIXED_PRESENT  = 3'd2;
   localparam logic [2:0] CSR_DEFAULT_TYPE   = 3'd3;
   localparam logic [2:0] CSR_VARIABLE_COUNT = 3'd4;
   localparam logic [2:0] CSR_PHYS_ADDR_BITS = 3'd5;

   typedef struct packed {
      logic [1:0]         action;
      logic [3:0]         entry_index;
      logic [VALUE_W-1:0] write_value;
      logic [ADDR_W-1:0]  lookup_address;
   } req_word_type;

   typedef struct packed {
      logic [2:0] memory_type;
      logic       type_conflict;
      logic       from_fixed;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic step;
      logic load;
      logic wr_fixed;
      logic wr_base;
      logic wr_mask;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
   } status_type;

   function automatic logic type_ok(input logic [7:0] t);
      type_ok = (t == {5'd0, TYPE_UC}) || (t == {5'd0, TYPE_WC}) ||
                (t == {5'd0, TYPE_WT}) || (t == {5'd0, TYPE_WP}) ||
                (t == {5'd0, TYPE_WB});
   endfunction

endpackage

`default_nettype wire

### src/memory_type_range_lookup_core.sv
// top level of the memory type range lookup block
// depends on mtrl_pkg, mtrl_ctrl and mtrl_dp
`default_nettype none

// usage
//  req channel: one word per item. action selects a lookup or a write of a
//  fixed range word, a variable base or a variable mask. writes finish in
//  the accept cycle and give no rsp word; a lookup gives exactly one.
//  rsp channel: memory type, conflict flag and a flag that the fixed ranges
//  decided. a held word stays put while rsp_ready is low.
//  csr channel: always ready; csr_index picks the control register, low
//  bits of csr_wdata are written. write only while the block is idle.
//  timing: a lookup walks the variable pairs one per cycle through a single
//  compare unit; the scan steps once per active pair (at most NUM_VARIABLE),
//  then sees the end of the scan, then resolves into the rsp register.
//  req_ready returns together with rsp_valid, so a new lookup is taken only
//  after the last one's rsp word is loaded. req_ready is high only in idle.
//  a stalled rsp does not block writes, but a following lookup holds in its
//  last step until the rsp register is free.
//  reset: synchronous; control registers go to their defaults, all range
//  stores read as zero and every mask is invalid. no clearing pass.
module memory_type_range_lookup_core #(
   parameter int NUM_VARIABLE = mtrl_pkg::MTRL_NUM_VARIABLE
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // item channel
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire mtrl_pkg::req_word_type req_word,
   // result channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output mtrl_pkg::rsp_word_type      rsp_word,
   // control register writes
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [2:0]             csr_index,
   input  wire logic [7:0]             csr_wdata
);
   import mtrl_pkg::*;

   cmd_type    cmd;
   status_type status;

   // registers are plain flops, a write never waits
   assign csr_ready = 1'b1;

   // sequencing: idle, scan over variable pairs, finish into rsp register
   mtrl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_word.action),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .status     (status)
   );

   // stores, match unit, resolution and the rsp register
   mtrl_dp #(
      .NUM_VARIABLE (NUM_VARIABLE)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_word  (req_word),
      .cmd       (cmd),
      .status    (status),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire

### src/mtrl_ctrl.sv
// controller state machine for the memory type range lookup block
// depends on mtrl_pkg; drives the datapath through cmd_type, reads status_type
`default_nettype none

module mtrl_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic [1:0]           req_action,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output mtrl_pkg::cmd_type         cmd,
   input  wire mtrl_pkg::status_type status
);
   import mtrl_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_accept;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_action)
                  ACT_LOOKUP: begin
                     cmd.start = 1'b1;
                     state_in  = ST_SCAN;
                  end
                  ACT_WR_FIXED: cmd.wr_fixed = 1'b1;
                  ACT_WR_BASE:  cmd.wr_base  = 1'b1;
                  ACT_WR_MASK:  cmd.wr_mask  = 1'b1;
                  default:      cmd        = '0;
               endcase
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_start_to_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (state_ff == ST_SCAN))
      else $error("lookup start did not enter scan");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending word");

   a_step_not_done: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !status.scan_done)
      else $error("scan stepped past the pair count");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> rsp_valid_ff)
      else $error("loaded result not presented");

endmodule

`default_nettype wire

### src/mtrl_dp.sv
// datapath: control registers, range stores, scan accumulator and result register
// depends on mtrl_pkg; steered by mtrl_ctrl through cmd_type
`default_nettype none

module mtrl_dp #(
   parameter int NUM_VARIABLE = mtrl_pkg::MTRL_NUM_VARIABLE
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write,
   input  wire logic [2:0]             csr_index,
   input  wire logic [7:0]             csr_wdata,
   input  wire mtrl_pkg::req_word_type req_word,
   input  wire mtrl_pkg::cmd_type      cmd,
   output mtrl_pkg::status_type        status,
   output mtrl_pkg::rsp_word_type      rsp_word
);
   import mtrl_pkg::*;

   localparam int CNT_W = $clog2(NUM_VARIABLE + 1);
   localparam int IDX_W = (NUM_VARIABLE > 1) ? $clog2(NUM_VARIABLE) : 1;

   // control registers
   logic       enable_ff, fixed_en_ff, fixed_pres_ff;
   logic [2:0] default_type_ff;
   logic [4:0] var_count_ff;
   logic [5:0] pab_ff;

   // range stores; valid bits give the all-zero reset value
   logic [VALUE_W-1:0] fixed_word_ff  [MTRL_NUM_FIXED];
   logic [MTRL_NUM_FIXED-1:0] fixed_valid_ff;
   logic [PAGE_W-1:0]  base_page_ff   [NUM_VARIABLE];
   logic [7:0]         base_type_ff   [NUM_VARIABLE];
   logic [NUM_VARIABLE-1:0] base_valid_ff;
   logic [PAGE_W-1:0]  mask_page_ff   [NUM_VARIABLE];
   logic [NUM_VARIABLE-1:0] mask_valid_ff;

   // scan state
   logic [ADDR_W-1:0] addr_ff;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [6:0]        set_ff, set_in;
   logic              bad_ff, bad_in;
   rsp_word_type      rsp_ff;

   logic              var_wr_ok, fixed_wr_ok;
   logic [IDX_W-1:0]  wr_idx, rd_idx;
   logic [4:0]        count_clamp;
   logic [CNT_W-1:0]  count_eff;
   logic [PAGE_W-1:0] limit_page, addr_page, e_base, e_mask;
   logic [7:0]        e_type;
   logic              e_hit;

   logic [FIXED_IDX_W-1:0] fword;
   logic [2:0]             fbyte_sel;
   logic [VALUE_W-1:0]     fword_val;
   logic [7:0]             fbyte;
   logic                   fixed_hit;
   rsp_word_type           res;

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff       <= 1'b0;
         fixed_en_ff     <= 1'b0;
         fixed_pres_ff   <= 1'b1;
         default_type_ff <= 3'd0;
         var_count_ff    <= 5'd8;
         pab_ff          <= 6'd46;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MTRR_ENABLE:    enable_ff       <= csr_wdata[0];
            CSR_FIXED_ENABLE:   fixed_en_ff     <= csr_wdata[0];
            CSR_FIXED_PRESENT:  fixed_pres_ff   <= csr_wdata[0];
            CSR_DEFAULT_TYPE:   default_type_ff <= csr_wdata[2:0];
            CSR_VARIABLE_COUNT: var_count_ff    <= csr_wdata[4:0];
            CSR_PHYS_ADDR_BITS: pab_ff          <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   // ---------------- range store writes ----------------
   assign fixed_wr_ok = req_word.entry_index < FIXED_IDX_W'(MTRL_NUM_FIXED);
   assign var_wr_ok   = {1'b0, req_word.entry_index} < 5'(NUM_VARIABLE);
   assign wr_idx      = req_word.entry_index[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.wr_fixed && fixed_wr_ok) begin
         fixed_word_ff[req_word.entry_index] <= req_word.write_value;
      end
      if (cmd.wr_base && var_wr_ok) begin
         base_page_ff[wr_idx] <= req_word.write_value[VALUE_W-1:PAGE_SHIFT];
         base_type_ff[wr_idx] <= req_word.write_value[7:0];
      end
      if (cmd.wr_mask && var_wr_ok) begin
         mask_page_ff[wr_idx] <= req_word.write_value[VALUE_W-1:PAGE_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fixed_valid_ff <= '0;
         base_valid_ff  <= '0;
         mask_valid_ff  <= '0;
      end else begin
         if (cmd.wr_fixed && fixed_wr_ok) begin
            fixed_valid_ff[req_word.entry_index] <= 1'b1;
         end
         if (cmd.wr_base && var_wr_ok) begin
            base_valid_ff[wr_idx] <= 1'b1;
         end
         if (cmd.wr_mask && var_wr_ok) begin
            mask_valid_ff[wr_idx] <= req_word.write_value[11];
         end
      end
   end

   // ---------------- variable pair scan ----------------
   assign count_clamp = (var_count_ff > 5'(NUM_VARIABLE)) ? 5'(NUM_VARIABLE) : var_count_ff;
   assign count_eff   = CNT_W'(count_clamp);
   assign status.scan_done = (idx_ff == count_eff);

   // page bit j is compared when its address bit lies below the address width
   always_comb begin
      for (int j = 0; j < PAGE_W; j++) begin
         limit_page[j] = (7'(j) + 7'(PAGE_SHIFT)) < {1'b0, pab_ff};
      end
   end

   assign addr_page = {{PAGE_SHIFT{1'b0}}, addr_ff[ADDR_W-1:PAGE_SHIFT]};
   assign rd_idx    = idx_ff[IDX_W-1:0];
   assign e_base    = base_valid_ff[rd_idx] ? base_page_ff[rd_idx] : '0;
   assign e_type    = base_valid_ff[rd_idx] ? base_type_ff[rd_idx] : 8'd0;
   assign e_mask    = mask_page_ff[rd_idx] & limit_page;
   assign e_hit     = mask_valid_ff[rd_idx] && (((addr_page ^ e_base) & e_mask) == '0);

   always_comb begin
      idx_in = idx_ff;
      set_in = set_ff;
      bad_in = bad_ff;
      if (cmd.start) begin
         idx_in = '0;
         set_in = '0;
         bad_in = 1'b0;
      end else if (cmd.step) begin
         idx_in = idx_ff + 1'b1;
         if (e_hit) begin
            if (type_ok(e_type)) begin
               set_in[e_type[2:0]] = 1'b1;
            end else begin
               bad_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         set_ff <= '0;
         bad_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         set_ff <= set_in;
         bad_ff <= bad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         addr_ff <= req_word.lookup_address;
      end
   end

   // ---------------- fixed ranges below one megabyte ----------------
   always_comb begin
      if (!addr_ff[19]) begin
         fword     = '0;                                  // 64k ranges
         fbyte_sel = addr_ff[18:16];
      end else if (!addr_ff[18]) begin
         fword     = FIXED_IDX_W'(1) + FIXED_IDX_W'(addr_ff[17]);    // 16k ranges
         fbyte_sel = addr_ff[16:14];
      end else begin
         fword     = FIXED_IDX_W'(3) + FIXED_IDX_W'(addr_ff[17:15]); // 4k ranges
         fbyte_sel = addr_ff[14:12];
      end
   end

   assign fword_val = fixed_valid_ff[fword] ? fixed_word_ff[fword] : '0;
   assign fbyte     = fword_val[{fbyte_sel, 3'b000} +: 8];
   assign fixed_hit = (addr_ff[ADDR_W-1:20] == '0) && fixed_pres_ff && fixed_en_ff;

   // ---------------- type resolution ----------------
   always_comb begin
      res = '{memory_type: TYPE_UC, type_conflict: 1'b0, from_fixed: 1'b0};
      if (enable_ff) begin
         if (fixed_hit) begin
            res.from_fixed = 1'b1;
            if (type_ok(fbyte)) begin
               res.memory_type = fbyte[2:0];
            end else begin
               res.type_conflict = 1'b1;
            end
         end else if (bad_ff) begin
            res.type_conflict = 1'b1;
         end else if (set_ff == '0) begin
            if (type_ok({5'd0, default_type_ff})) begin
               res.memory_type = default_type_ff;
            end else begin
               res.type_conflict = 1'b1;
            end
         end else if (set_ff[TYPE_UC]) begin
            res.memory_type = TYPE_UC;
         end else begin
            case (set_ff)
               SET_WC:    res.memory_type = TYPE_WC;
               SET_WT:    res.memory_type = TYPE_WT;
               SET_WP:    res.memory_type = TYPE_WP;
               SET_WB:    res.memory_type = TYPE_WB;
               SET_WT_WB: res.memory_type = TYPE_WT;
               default:   res.type_conflict = 1'b1;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_ff <= res;
      end
   end

   assign rsp_word = rsp_ff;

endmodule

`default_nettype wire

### tb/tb.sv
// self-checking testbench for memory_type_range_lookup_core
// depends on mtrl_pkg and the rtl of the block; carries its own lookup predictor
`timescale 1ns / 100ps

module tb;
   import mtrl_pkg::*;

   // settle time after the last rsp word: a full scan plus margin
   localparam int SETTLE_CYCLES   = MTRL_NUM_VARIABLE + 8;
   localparam int PHASE_WORDS     = 78;
   localparam int NUM_PHASES      = 8;
   // csr indexes past the last register, written only to see them ignored
   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [7:0]   csr_wdata = '0;

   memory_type_range_lookup_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // predictor copy of the control registers, reset values
   logic       cfg_enable        = 1'b0;
   logic       cfg_fixed_enable  = 1'b0;
   logic       cfg_fixed_present = 1'b1;
   logic [2:0] cfg_default_type  = TYPE_UC;
   logic [4:0] cfg_var_count     = 5'd8;
   logic [5:0] cfg_addr_bits     = 6'd46;

   // predictor copy of the range stores
   logic [63:0] fixed_words [MTRL_NUM_FIXED];
   logic [59:0] var_bases   [MTRL_NUM_VARIABLE];   // base page, type byte
   logic [52:0] var_masks   [MTRL_NUM_VARIABLE];   // mask page, valid

   // what the stimulus generator last wrote, used to aim lookups at ranges
   logic [63:0] aim_bases [MTRL_NUM_VARIABLE];
   logic [63:0] aim_masks [MTRL_NUM_VARIABLE];

   req_word_type request_backlog [$];
   rsp_word_type expected_types  [$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int mismatch_count = 0;
   int rsp_count      = 0;

   function automatic logic legal_type(input logic [7:0] code);
      case (code)
         {5'd0, TYPE_UC}, {5'd0, TYPE_WC}, {5'd0, TYPE_WT},
         {5'd0, TYPE_WP}, {5'd0, TYPE_WB}: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // memory type of one address under the current registers and stores
   function automatic rsp_word_type predict_memory_type(input logic [ADDR_W-1:0] addr);
      rsp_word_type r;
      logic [7:0]   code;
      logic [6:0]   hit_types;
      logic         bad;
      logic [63:0]  limit, mask, base, addr64;
      int           word, lane, count;
      r = '0;
      r.memory_type = TYPE_UC;
      if (!cfg_enable)
         return r;
      if (addr < 52'h100000 && cfg_fixed_present && cfg_fixed_enable) begin
         // one 64k lane per byte, then 16k lanes, then 4k lanes
         if (addr < 52'h80000) begin
            word = 0;
            lane = int'(addr[18:16]);
         end else if (addr < 52'hC0000) begin
            word = 1 + int'((addr - 52'h80000) >> 17);
            lane = int'(addr[16:14]);
         end else begin
            word = 3 + int'((addr - 52'hC0000) >> 15);
            lane = int'(addr[14:12]);
         end
         code = fixed_words[word][lane*8 +: 8];
         r.from_fixed = 1'b1;
         if (legal_type(code))
            r.memory_type = code[2:0];
         else
            r.type_conflict = 1'b1;
         return r;
      end
      // variable pairs: collect the type of every valid matching pair
      count     = (cfg_var_count > MTRL_NUM_VARIABLE) ? MTRL_NUM_VARIABLE : cfg_var_count;
      limit     = (64'd1 << cfg_addr_bits) - 64'd1;
      addr64    = {12'd0, addr};
      hit_types = '0;
      bad       = 1'b0;
      for (int i = 0; i < count; i++) begin
         if (var_masks[i][0]) begin
            mask = {var_masks[i][52:1], 12'd0} & limit;
            base = {var_bases[i][59:8], 12'd0};
            if (((addr64 ^ base) & mask) == 64'd0) begin
               code = var_bases[i][7:0];
               if (legal_type(code))
                  hit_types[code[2:0]] = 1'b1;
               else
                  bad = 1'b1;
            end
         end
      end
      // resolve: uc wins, wt beats wb, anything else mixed is a conflict
      if (bad) begin
         r.type_conflict = 1'b1;
      end else if (hit_types == '0) begin
         if (legal_type({5'd0, cfg_default_type}))
            r.memory_type = cfg_default_type;
         else
            r.type_conflict = 1'b1;
      end else if (hit_types[TYPE_UC]) begin
         r.memory_type = TYPE_UC;
      end else if (hit_types == SET_WC) begin
         r.memory_type = TYPE_WC;
      end else if (hit_types == SET_WT || hit_types == SET_WT_WB) begin
         r.memory_type = TYPE_WT;
      end else if (hit_types == SET_WP) begin
         r.memory_type = TYPE_WP;
      end else if (hit_types == SET_WB) begin
         r.memory_type = TYPE_WB;
      end else begin
         r.type_conflict = 1'b1;
      end
      return r;
   endfunction

   // apply one accepted req word to the predictor state
   function automatic void apply_request(input req_word_type w);
      logic [63:0] v;
      v = w.write_value;
      case (w.action)
         ACT_WR_FIXED: begin
            // indexes past the last fixed word are dropped
            if (w.entry_index < MTRL_NUM_FIXED)
               fixed_words[w.entry_index] = v;
         end
         ACT_WR_BASE: begin
            if (w.entry_index < MTRL_NUM_VARIABLE)
               var_bases[w.entry_index] = {v[63:12], v[7:0]};
         end
         ACT_WR_MASK: begin
            if (w.entry_index < MTRL_NUM_VARIABLE)
               var_masks[w.entry_index] = {v[63:12], v[11]};
         end
         default: begin
            expected_types.push_back(predict_memory_type(w.lookup_address));
         end
      endcase
   endfunction

   function automatic logic [7:0] pick_type();
      case ($urandom_range(6))
         0:       return {5'd0, TYPE_UC};
         1:       return {5'd0, TYPE_WC};
         2, 3:    return {5'd0, TYPE_WT};
         4:       return {5'd0, TYPE_WP};
         default: return {5'd0, TYPE_WB};
      endcase
   endfunction

   // one random req word; writes mostly carry legal types, lookups mostly
   // land in the fixed area or inside a range that was just written
   function automatic req_word_type make_request();
      req_word_type w;
      logic [63:0]  v;
      logic [51:0]  page_mask;
      int           pick, k, span;
      w.action         = ACT_LOOKUP;
      w.entry_index    = 4'($urandom);
      w.write_value    = {$urandom, $urandom};
      w.lookup_address = 52'({$urandom, $urandom});
      pick = $urandom_range(99);
      if (pick < 15) begin
         w.action      = ACT_WR_FIXED;
         w.entry_index = 4'(($urandom_range(9) == 0) ? $urandom_range(15, 11)
                                                      : $urandom_range(10));
         for (k = 0; k < 8; k++)
            w.write_value[k*8 +: 8] = ($urandom_range(9) == 0) ? 8'($urandom) : pick_type();
      end else if (pick < 28) begin
         k = $urandom_range(15);
         w.action      = ACT_WR_BASE;
         w.entry_index = 4'(k);
         v = {$urandom, $urandom};
         // keep most bases within 4 gb so that ranges overlap
         if ($urandom_range(9) != 0) begin
            v[63:32] = '0;
            v[7:0]   = pick_type();
         end
         w.write_value = v;
         aim_bases[k]  = v;
      end else if (pick < 40) begin
         k = $urandom_range(15);
         w.action      = ACT_WR_MASK;
         w.entry_index = 4'(k);
         span = ($urandom_range(3) == 0) ? $urandom_range(52, 12) : $urandom_range(32, 12);
         v = ~((64'd1 << span) - 64'd1);
         v[11:0] = 12'($urandom);
         v[11]   = ($urandom_range(9) != 0);
         if ($urandom_range(19) == 0)
            v = {$urandom, $urandom};
         w.write_value = v;
         aim_masks[k]  = v;
      end else begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            w.lookup_address = 52'($urandom_range(32'hFFFFF));
         end else if (pick < 80) begin
            k = $urandom_range(15);
            page_mask = aim_masks[k][51:0] & 52'hF_FFFF_FFFF_F000;
            w.lookup_address = (aim_bases[k][51:0] & page_mask) |
                               (w.lookup_address & ~page_mask);
         end
      end
      return w;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("tb: mismatch %s", msg);
   endtask

   task automatic queue_item(input logic [1:0] act, input logic [3:0] idx,
                             input logic [63:0] value, input logic [51:0] addr);
      req_word_type w;
      w.action         = act;
      w.entry_index    = idx;
      w.write_value    = value;
      w.lookup_address = addr;
      request_backlog.push_back(w);
   endtask

   // call right after a rising edge; valid stays high across back to back
   // writes, the caller lowers it after the last one
   task automatic write_control(input logic [2:0] idx, input logic [7:0] data);
      if (!csr_valid)
         csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_MTRR_ENABLE:    cfg_enable        = data[0];
         CSR_FIXED_ENABLE:   cfg_fixed_enable  = data[0];
         CSR_FIXED_PRESENT:  cfg_fixed_present = data[0];
         CSR_DEFAULT_TYPE:   cfg_default_type  = data[2:0];
         CSR_VARIABLE_COUNT: cfg_var_count     = data[4:0];
         CSR_PHYS_ADDR_BITS: cfg_addr_bits     = data[5:0];
         default: ;
      endcase
   endtask

   // all six registers plus the spare indexes; unused data bits are random
   task automatic load_settings(input logic en, input logic fen, input logic fpres,
                                input logic [2:0] dflt, input logic [4:0] count,
                                input logic [5:0] bits);
      logic [7:0] junk;
      junk = 8'($urandom);
      write_control(CSR_MTRR_ENABLE, {junk[7:1], en});
      junk = 8'($urandom);
      write_control(CSR_FIXED_ENABLE, {junk[7:1], fen});
      junk = 8'($urandom);
      write_control(CSR_FIXED_PRESENT, {junk[7:1], fpres});
      junk = 8'($urandom);
      write_control(CSR_DEFAULT_TYPE, {junk[7:3], dflt});
      junk = 8'($urandom);
      write_control(CSR_VARIABLE_COUNT, {junk[7:5], count});
      junk = 8'($urandom);
      write_control(CSR_PHYS_ADDR_BITS, {junk[7:6], bits});
      write_control(CSR_SPARE_LO, 8'($urandom));
      write_control(CSR_SPARE_HI, 8'($urandom));
      csr_valid <= 1'b0;
   endtask

   // hold until every queued word is sent and every rsp word is back;
   // sampled on the falling edge so the driver's updates have landed
   task automatic wait_idle();
      while (request_backlog.size() != 0 || req_valid || expected_types.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // req driver: predicts at the accept edge, then offers the next word
   always @(posedge clock) begin : req_driver
      logic taken;
      taken = req_valid && req_ready;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (taken)
            apply_request(req_word);
         if (!req_valid || taken) begin
            if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_word  <= request_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // rsp monitor: checks each accepted word against the oldest prediction
   always @(posedge clock) begin : rsp_monitor
      rsp_word_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (expected_types.size() == 0) begin
               report_mismatch($sformatf("rsp %0d arrived with no lookup outstanding",
                                         rsp_count));
            end else begin
               want = expected_types.pop_front();
               if (rsp_word.memory_type !== want.memory_type)
                  report_mismatch($sformatf("rsp %0d memory_type got %0d want %0d",
                                            rsp_count, rsp_word.memory_type,
                                            want.memory_type));
               if (rsp_word.type_conflict !== want.type_conflict)
                  report_mismatch($sformatf("rsp %0d type_conflict got %0b want %0b",
                                            rsp_count, rsp_word.type_conflict,
                                            want.type_conflict));
               if (rsp_word.from_fixed !== want.from_fixed)
                  report_mismatch($sformatf("rsp %0d from_fixed got %0b want %0b",
                                            rsp_count, rsp_word.from_fixed,
                                            want.from_fixed));
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin : stimulus
      int p, k;
      for (k = 0; k < MTRL_NUM_FIXED; k++)
         fixed_words[k] = '0;
      for (k = 0; k < MTRL_NUM_VARIABLE; k++) begin
         var_bases[k] = '0;
         var_masks[k] = '0;
         aim_bases[k] = '0;
         aim_masks[k] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // out of reset the block is disabled: everything reads uc
      queue_item(ACT_LOOKUP, 4'd0, 64'd0, 52'h1_0000_0000);
      wait_idle();

      load_settings(1'b1, 1'b1, 1'b1, TYPE_WB, 5'd16, 6'd52);
      // fixed words: word 0 has a reserved code in its second lane,
      // word 10 has 0xff in its top lane, index 11 must be dropped
      queue_item(ACT_WR_FIXED, 4'd0,  64'h0605_0401_0006_0704, 52'd0);
      queue_item(ACT_WR_FIXED, 4'd10, 64'hFF06_0504_0100_0606, 52'd0);
      queue_item(ACT_WR_FIXED, 4'd11, 64'hFFFF_FFFF_FFFF_FFFF, 52'd0);
      queue_item(ACT_LOOKUP, 4'd0, 64'd0, 52'h0_0000);
      queue_item(ACT_LOOKUP, 4'd0, 64'd0, 52'h1_0000);
      queue_item(ACT_LOOKUP, 4'd0, 64'd0, 52'h7_FFFF);
      queue_item(ACT_LOOKUP, 4'd0, 64'd0, 52'h8_0000);
      queue_item(ACT_LOOKUP, 4'd0, 64'd0, 52'hF_8000);
      queue_item(ACT_LOOKUP, 4'd0, 64'd0, 52'hF_FFFF);
      // variable pairs: wb over a gigabyte with wt inside it, a uc range,
      // a reserved type code, and a 4k wc page overlapping the wb range
      queue_item(ACT_WR_BASE, 4'd0, 64'h1_0000_0000 | TYPE_WB, 52'd0);
      queue_item(ACT_WR_MASK, 4'd0, 64'hFFFF_FFFF_C000_0800, 52'd0);
      queue_item(ACT_WR_BASE, 4'd1, 64'h1_0000_0000 | TYPE_WT, 52'd0);
      queue_item(ACT_WR_MASK, 4'd1, 64'hFFFF_FFFF_FFE0_0800, 52'd0);
      queue_item(ACT_WR_BASE, 4'd2, 64'h2_0000_0000 | TYPE_UC, 52'd0);
      queue_item(ACT_WR_MASK, 4'd2, 64'hFFFF_FFFF_C000_0800, 52'd0);
      queue_item(ACT_WR_BASE, 4'd3, 64'h3_0000_0003, 52'd0);
      queue_item(ACT_WR_MASK, 4'd3, 64'hFFFF_FFFF_C000_0800, 52'd0);
      queue_item(ACT_WR_BASE, 4'd4, 64'h1_3000_0000 | TYPE_WC, 52'd0);
      queue_item(ACT_WR_MASK, 4'd4, 64'hFFFF_FFFF_FFFF_F800, 52'd0);
      // last pair all ones: full mask, 0xff type, top of the address space
      queue_item(ACT_WR_BASE, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 52'd0);
      queue_item(ACT_WR_MASK, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 52'd0);
      queue_item(ACT_LOOKUP, 4'd0, 64'd0, 52'h1_0000_0000);
      queue_item(ACT_LOOKUP, 4'd0, 64'd0, 52'h1_2000_0000);
      queue_item(ACT_LOOKUP, 4'd0, 64'd0, 52'h1_3000_0000);
      queue_item(ACT_LOOKUP, 4'd0, 64'd0, 52'h2_0000_1000);
      queue_item(ACT_LOOKUP, 4'd0, 64'd0, 52'h3_0000_0000);
      queue_item(ACT_LOOKUP, 4'd0, 64'd0, 52'h5_0000_0000);
      queue_item(ACT_LOOKUP, 4'd0, 64'd0, 52'hF_FFFF_FFFF_FFFF);
      wait_idle();

      for (p = 0; p < NUM_PHASES; p++) begin
         // registers change only here, with the block drained
         case (p)
            0: load_settings(1'b1, 1'b1, 1'b1, TYPE_WB, 5'd16, 6'd46);
            1: load_settings(1'b1, 1'b1, 1'b0, TYPE_UC, 5'd8,  6'd36);
            2: load_settings(1'b1, 1'b0, 1'b1, TYPE_WT, 5'd0,  6'd52);
            3: load_settings(1'b0, 1'b1, 1'b1, TYPE_WB, 5'd16, 6'd52);
            // reserved default code, count clamped to the pair count, widest mask
            4: load_settings(1'b1, 1'b1, 1'b1, 3'd7,    5'd31, 6'd63);
            // zero width: every valid pair matches everything
            5: load_settings(1'b1, 1'b1, 1'b1, 3'd2,    5'd5,  6'd0);
            6: load_settings(1'b1, 1'b0, 1'b0, TYPE_WP, 5'd1,  6'd40);
            default: load_settings(1'b1, 1'b1, 1'b1, TYPE_WC, 5'd17, 6'd48);
         endcase
         // idling pattern: none, sender gaps, receiver stalls, both
         case (p % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 71; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 71; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
         endcase
         for (k = 0; k < PHASE_WORDS; k++) begin
            // once, mid phase 2, the sender holds until every rsp word is back
            if (p == 2 && k == PHASE_WORDS / 2)
               wait_idle();
            request_backlog.push_back(make_request());
         end
         wait_idle();
      end

      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin : watchdog
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
